[sv/clkpr_pkg.sv]
// Shared types and constants for the clock page replacement block.
// Holds field widths, parameter defaults and the sequencer state type.
// No dependencies.
`default_nettype none

package clkpr_pkg;

  localparam int IN_PAGE_W     = 20;
  localparam int FRAME_W       = 6;
  localparam int FAULT_W       = 16;
  localparam int DEF_FRAMES    = 4;
  localparam int DEF_PAGE_BITS = 20;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SWEEP
  } clkpr_state_t;

endpackage

`default_nettype wire

[sv/clkpr_store.sv]
// Page number store for the clock page replacement block.
// One write port, one registered read port, and the shared page comparator.
// Depends on clkpr_pkg for parameter defaults.
`default_nettype none

module clkpr_store #(
  parameter int FRAMES    = clkpr_pkg::DEF_FRAMES,
  parameter int PAGE_BITS = clkpr_pkg::DEF_PAGE_BITS
) (
  input  wire logic                        clk,
  input  wire logic                        wr_en,
  input  wire logic [$clog2(FRAMES)-1:0]   wr_addr,
  input  wire logic [PAGE_BITS-1:0]        wr_data,
  input  wire logic [$clog2(FRAMES)-1:0]   rd_addr,
  input  wire logic [PAGE_BITS-1:0]        cmp_page,
  output logic                             match
);

  logic [PAGE_BITS-1:0] mem [FRAMES];
  logic [PAGE_BITS-1:0] rd_q_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_q_r <= mem[rd_addr];
  end

  // Compare the frame read in the previous cycle against the page in flight.
  assign match = (rd_q_r == cmp_page);

endmodule

`default_nettype wire

[sv/clock_page_replacement.sv]
// Top level of the clock (second-chance) page replacement block.
// Sequencer, frame valid/reference bits, clock hand and fault counter.
// Depends on clkpr_pkg and clkpr_store.
`default_nettype none

// One page access is accepted when start is high and busy is low; busy stays
// high until the result is produced. The block scans the frames one per cycle
// through the single read port of the page store and one comparator: a hit in
// frame i ends the scan and strobes its result. A miss takes the lowest free
// frame when one exists; with all frames full the clock hand then steps one
// frame per cycle, clearing each set reference bit that it passes, and takes
// the first frame with a clear reference bit as the victim. The
// result is shown for exactly one cycle with out_valid and must be taken then:
// there is no backpressure. A new access may be started in that same cycle.
module clock_page_replacement #(
  parameter int FRAMES    = clkpr_pkg::DEF_FRAMES,
  parameter int PAGE_BITS = clkpr_pkg::DEF_PAGE_BITS
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [clkpr_pkg::IN_PAGE_W-1:0] in_page_number,
  output logic                                 out_valid,
  output logic                                 out_hit,
  output logic [clkpr_pkg::FRAME_W-1:0]        out_frame_index,
  output logic [clkpr_pkg::FAULT_W-1:0]        out_fault_total
);

  import clkpr_pkg::*;

  localparam int IW = $clog2(FRAMES);
  localparam logic [IW-1:0] LAST = IW'(FRAMES - 1);

  clkpr_state_t state_r, state_nxt;

  logic [PAGE_BITS-1:0] page_r, page_nxt;
  logic [IW-1:0]        idx_r, idx_nxt;
  logic                 iss_r, iss_nxt;
  logic [IW-1:0]        cmp_idx_r, cmp_idx_nxt;
  logic                 cmp_live_r, cmp_live_nxt;
  logic                 free_found_r, free_found_nxt;
  logic [IW-1:0]        free_idx_r, free_idx_nxt;
  logic [IW-1:0]        hand_r, hand_nxt;
  logic [FRAMES-1:0]    valid_r, valid_nxt;
  logic [FRAMES-1:0]    ref_r, ref_nxt;
  logic [FAULT_W-1:0]   fault_r, fault_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_hit_r, out_hit_nxt;
  logic [FRAME_W-1:0]   out_frame_r, out_frame_nxt;
  logic [FAULT_W-1:0]   out_fault_r, out_fault_nxt;

  logic                 wr_en;
  logic [IW-1:0]        wr_addr;
  logic                 match;
  logic                 free_now;
  logic [IW-1:0]        free_sel;
  logic [IW-1:0]        hand_adv;

  clkpr_store #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_store (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (page_r),
    .rd_addr  (idx_r),
    .cmp_page (page_r),
    .match    (match)
  );

  assign hand_adv = (hand_r == LAST) ? '0 : hand_r + IW'(1);
  assign free_now = free_found_r || !valid_r[cmp_idx_r];
  assign free_sel = free_found_r ? free_idx_r : cmp_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      ref_r       <= '0;
      hand_r      <= '0;
      fault_r     <= '0;
      out_valid_r <= 1'b0;
      iss_r       <= 1'b0;
      cmp_live_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      ref_r       <= ref_nxt;
      hand_r      <= hand_nxt;
      fault_r     <= fault_nxt;
      out_valid_r <= out_valid_nxt;
      iss_r       <= iss_nxt;
      cmp_live_r  <= cmp_live_nxt;
    end
  end

  always_ff @(posedge clk) begin
    page_r       <= page_nxt;
    idx_r        <= idx_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    out_hit_r    <= out_hit_nxt;
    out_frame_r  <= out_frame_nxt;
    out_fault_r  <= out_fault_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    page_nxt       = page_r;
    idx_nxt        = idx_r;
    iss_nxt        = iss_r;
    cmp_idx_nxt    = cmp_idx_r;
    cmp_live_nxt   = 1'b0;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    hand_nxt       = hand_r;
    valid_nxt      = valid_r;
    ref_nxt        = ref_r;
    fault_nxt      = fault_r;
    out_valid_nxt  = 1'b0;
    out_hit_nxt    = out_hit_r;
    out_frame_nxt  = out_frame_r;
    out_fault_nxt  = out_fault_r;
    wr_en          = 1'b0;
    wr_addr        = hand_r;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          page_nxt       = PAGE_BITS'(in_page_number);
          idx_nxt        = '0;
          iss_nxt        = 1'b1;
          free_found_nxt = 1'b0;
          state_nxt      = ST_SCAN;
        end
      end

      ST_SCAN: begin
        // Issue one frame read per cycle; its compare lands in the next cycle.
        if (iss_r) begin
          cmp_idx_nxt  = idx_r;
          cmp_live_nxt = 1'b1;
          if (idx_r == LAST) begin
            iss_nxt = 1'b0;
          end else begin
            idx_nxt = idx_r + IW'(1);
          end
        end
        if (cmp_live_r) begin
          if (valid_r[cmp_idx_r] && match) begin
            ref_nxt[cmp_idx_r] = 1'b1;
            out_valid_nxt      = 1'b1;
            out_hit_nxt        = 1'b1;
            out_frame_nxt      = FRAME_W'(cmp_idx_r);
            out_fault_nxt      = fault_r;
            iss_nxt            = 1'b0;
            state_nxt          = ST_IDLE;
          end else begin
            // Remember the lowest free frame seen so far.
            if (!valid_r[cmp_idx_r] && !free_found_r) begin
              free_found_nxt = 1'b1;
              free_idx_nxt   = cmp_idx_r;
            end
            if (cmp_idx_r == LAST) begin
              fault_nxt = (&fault_r) ? fault_r : fault_r + FAULT_W'(1);
              if (free_now) begin
                wr_en             = 1'b1;
                wr_addr           = free_sel;
                valid_nxt[free_sel] = 1'b1;
                ref_nxt[free_sel] = 1'b1;
                hand_nxt          = hand_adv;
                out_valid_nxt     = 1'b1;
                out_hit_nxt       = 1'b0;
                out_frame_nxt     = FRAME_W'(free_sel);
                out_fault_nxt     = fault_nxt;
                state_nxt         = ST_IDLE;
              end else begin
                state_nxt = ST_SWEEP;
              end
            end
          end
        end
      end

      ST_SWEEP: begin
        // Give a referenced frame its second chance, else take it as victim.
        if (ref_r[hand_r]) begin
          ref_nxt[hand_r] = 1'b0;
          hand_nxt        = hand_adv;
        end else begin
          wr_en             = 1'b1;
          wr_addr           = hand_r;
          valid_nxt[hand_r] = 1'b1;
          ref_nxt[hand_r]   = 1'b1;
          hand_nxt          = hand_adv;
          out_valid_nxt     = 1'b1;
          out_hit_nxt       = 1'b0;
          out_frame_nxt     = FRAME_W'(hand_r);
          out_fault_nxt     = fault_r;
          state_nxt         = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_frame_index = out_frame_r;
  assign out_fault_total = out_fault_r;

  // The sweep only runs when every frame is occupied.
  a_sweep_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWEEP) |-> (&valid_r))
    else $error("sweep entered with a free frame");

  // A reported frame is occupied and referenced.
  a_result_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (valid_r[out_frame_r[IW-1:0]] && ref_r[out_frame_r[IW-1:0]]))
    else $error("result frame not valid or not referenced");

  // Each transaction yields a single one-cycle strobe.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe longer than one cycle");

  // The fault count never goes down.
  a_fault_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (fault_r >= $past(fault_r)))
    else $error("fault counter decreased");

endmodule

`default_nettype wire

[sim/tb_clock_page_replacement.sv]
// Self-checking testbench for the clock (second-chance) page replacement block.
// Drives page accesses through the start/busy port and checks every result strobe
// against a second-chance predictor kept in a scoreboard class. Depends on clkpr_pkg and clock_page_replacement.
`timescale 1ns / 1ps

module tb_clock_page_replacement;
  import clkpr_pkg::*;

  localparam int FRAMES    = DEF_FRAMES;
  localparam int PAGE_BITS = DEF_PAGE_BITS;
  localparam logic [IN_PAGE_W-1:0] PAGE_MASK = IN_PAGE_W'((64'd1 << PAGE_BITS) - 64'd1);
  localparam int FAULT_MAX = (1 << FAULT_W) - 1;
  localparam int RANDOM_ITEMS = 520;
  localparam int POOL_SIZE = 8;
  localparam int DRAIN_CYCLES = 4 * FRAMES + 8;

  typedef struct packed {
    logic                 hit;
    logic [FRAME_W-1:0]   frame;
    logic [FAULT_W-1:0]   faults;
  } access_result_t;

  class page_hit_scoreboard;
    logic [IN_PAGE_W-1:0] frame_page [FRAMES];
    bit                   frame_valid[FRAMES];
    bit                   referenced [FRAMES];
    int unsigned          hand;
    int unsigned          fault_count;
    access_result_t       expected_q[$];
    int                   errors;

    function new();
      for (int i = 0; i < FRAMES; i++) begin
        frame_page[i]  = '0;
        frame_valid[i] = 1'b0;
        referenced[i]  = 1'b0;
      end
      hand        = 0;
      fault_count = 0;
      errors      = 0;
    endfunction

    // Predict the outcome of one accepted transaction and queue it.
    function void note_access(logic [IN_PAGE_W-1:0] raw_page);
      logic [IN_PAGE_W-1:0] page;
      int                   used;
      bit                   hit;
      bit                   placed;
      access_result_t       res;
      page   = raw_page & PAGE_MASK;
      used   = 0;
      hit    = 1'b0;
      placed = 1'b0;
      for (int i = 0; i < FRAMES; i++) begin
        if (!hit && frame_valid[i] && frame_page[i] == page) begin
          referenced[i] = 1'b1;
          used = i;
          hit  = 1'b1;
        end
      end
      if (!hit) begin
        if (fault_count < FAULT_MAX) fault_count++;
        for (int i = 0; i < FRAMES; i++) begin
          if (!placed && !frame_valid[i]) begin
            frame_page[i]  = page;
            frame_valid[i] = 1'b1;
            referenced[i]  = 1'b1;
            used   = i;
            placed = 1'b1;
          end
        end
        if (placed) begin
          hand = (hand + 1) % FRAMES;
        end else begin
          // clear second chances until a frame with a clear bit turns up
          for (int s = 0; s <= FRAMES; s++) begin
            if (!referenced[hand]) break;
            referenced[hand] = 1'b0;
            hand = (hand + 1) % FRAMES;
          end
          used = hand;
          frame_page[used]  = page;
          frame_valid[used] = 1'b1;
          referenced[used]  = 1'b1;
          hand = (hand + 1) % FRAMES;
        end
      end
      res.hit    = hit;
      res.frame  = FRAME_W'(used);
      res.faults = FAULT_W'(fault_count);
      expected_q.push_back(res);
    endfunction

    function void check_result(logic hit, logic [FRAME_W-1:0] frame,
                               logic [FAULT_W-1:0] faults);
      access_result_t exp_res;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result hit %0d frame %0d faults %0d",
                 $time, hit, frame, faults);
        errors++;
        return;
      end
      exp_res = expected_q.pop_front();
      if (hit !== exp_res.hit) begin
        $display("%0t: hit expected %0d actual %0d", $time, exp_res.hit, hit);
        errors++;
      end
      if (frame !== exp_res.frame) begin
        $display("%0t: frame_index expected %0d actual %0d", $time, exp_res.frame, frame);
        errors++;
      end
      if (faults !== exp_res.faults) begin
        $display("%0t: fault_total expected %0d actual %0d", $time, exp_res.faults, faults);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic [IN_PAGE_W-1:0]     in_page_number;
  logic                     out_valid;
  logic                     out_hit;
  logic [FRAME_W-1:0]       out_frame_index;
  logic [FAULT_W-1:0]       out_fault_total;

  page_hit_scoreboard       sb;
  logic [IN_PAGE_W-1:0]     page_pool[POOL_SIZE];

  clock_page_replacement #(
    .FRAMES   (FRAMES),
    .PAGE_BITS(PAGE_BITS)
  ) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_page_number (in_page_number),
    .out_valid      (out_valid),
    .out_hit        (out_hit),
    .out_frame_index(out_frame_index),
    .out_fault_total(out_fault_total)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #60_000_000;
    $display("FAIL");
    $finish;
  end

  // Check results before noting a new transaction: a strobe always belongs to
  // an earlier access.
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (out_valid === 1'b1) sb.check_result(out_hit, out_frame_index, out_fault_total);
      if (start === 1'b1 && busy === 1'b0) sb.note_access(in_page_number);
    end
  end

  task automatic send_access(input logic [IN_PAGE_W-1:0] page, input int gap);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start          <= 1'b1;
    in_page_number <= page;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [IN_PAGE_W-1:0] random_page();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return IN_PAGE_W'($urandom());
    endcase
  endfunction

  // Mostly a small working set so hits and second chances happen, with some
  // pages from the whole range mixed in.
  function automatic logic [IN_PAGE_W-1:0] pick_page();
    if ($urandom_range(0, 15) == 0) page_pool[$urandom_range(0, POOL_SIZE - 1)] = random_page();
    if ($urandom_range(0, 3) == 0) return random_page();
    return page_pool[$urandom_range(0, FRAMES + 1)];
  endfunction

  task automatic run_random(input int count);
    int sent;
    int burst;
    int gap;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 24);
      gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
      for (int b = 0; b < burst && sent < count; b++) begin
        send_access(pick_page(), (b == 0) ? gap : 0);
        sent++;
      end
      if ($urandom_range(0, 9) == 0) drain_results();
    end
  endtask

  initial begin
    logic [IN_PAGE_W-1:0] directed[$];
    sb             = new();
    rst_n          = 1'b0;
    start          = 1'b0;
    in_page_number = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Fill with page zero and the extremes, hit them, then force a full sweep
    // and a partial one, and evict page zero.
    directed = '{20'h00000, 20'h00000, 20'hFFFFF, 20'h00001, 20'h80000, 20'hFFFFF,
                 20'h00001, 20'h12345, 20'h00000, 20'h80000, 20'h55555, 20'h2AAAA,
                 20'h2AAAA, 20'h12345, 20'hFFFFF, 20'h7FFFF, 20'h00000, 20'h55555};
    foreach (directed[i]) send_access(directed[i], (i % 3 == 0) ? $urandom_range(0, 4) : 0);
    drain_results();

    for (int i = 0; i < POOL_SIZE; i++) page_pool[i] = random_page();
    run_random(RANDOM_ITEMS);
    drain_results();

    run_random(60);

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("%0t: %0d results never arrived", $time, sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
